>>> rtl/ipfe_pkg.sv
// Shared types and constants for the IR pulse frame encoder.
// Holds the register map, the frame phase codes and the item structures.
// No dependencies.
`timescale 1ns / 1ps

package ipfe_pkg;

    localparam int DUR_W   = 15;
    localparam int ADDR_W  = 16;
    localparam int CMD_W   = 15;
    localparam int LEN_W   = 12;
    localparam int OPT_W   = 3;
    localparam int CFG_W   = 15;
    localparam int IDX_W   = 3;

    localparam int ADDR_MAX_BITS = 16;
    localparam int CMD_MAX_BITS  = 15;

    // Frame option bits.
    localparam int OPT_ADDR_INV = 0;
    localparam int OPT_CMD_INV  = 1;
    localparam int OPT_STOP     = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_HEADER_MARK   = 3'd0,
        REG_HEADER_SPACE  = 3'd1,
        REG_ONE_MARK      = 3'd2,
        REG_ONE_SPACE     = 3'd3,
        REG_ZERO_MARK     = 3'd4,
        REG_ZERO_SPACE    = 3'd5,
        REG_FIELD_LENGTHS = 3'd6,
        REG_FRAME_OPTIONS = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_ADDR     = 3'd1,
        PH_ADDR_INV = 3'd2,
        PH_CMD      = 3'd3,
        PH_CMD_INV  = 3'd4,
        PH_STOP     = 3'd5
    } phase_t;

    localparam int PH_NUM = 6;

    typedef struct packed {
        logic [DUR_W-1:0] header_mark;
        logic [DUR_W-1:0] header_space;
        logic [DUR_W-1:0] one_mark;
        logic [DUR_W-1:0] one_space;
        logic [DUR_W-1:0] zero_mark;
        logic [DUR_W-1:0] zero_space;
        logic [LEN_W-1:0] field_lengths;
        logic [OPT_W-1:0] frame_options;
    } cfg_t;

    typedef struct packed {
        logic [DUR_W-1:0] mark;
        logic [DUR_W-1:0] space;
        logic             last;
    } item_t;

endpackage

>>> rtl/ipfe_cfg_regs.sv
// Configuration register file of the IR pulse frame encoder.
// Depends on ipfe_pkg for the register map and cfg_t.
`timescale 1ns / 1ps

module ipfe_cfg_regs
    import ipfe_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0] cfg_wr_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_wr_index))
                REG_HEADER_MARK:   cfg_next.header_mark   = cfg_wr_data[DUR_W-1:0];
                REG_HEADER_SPACE:  cfg_next.header_space  = cfg_wr_data[DUR_W-1:0];
                REG_ONE_MARK:      cfg_next.one_mark      = cfg_wr_data[DUR_W-1:0];
                REG_ONE_SPACE:     cfg_next.one_space     = cfg_wr_data[DUR_W-1:0];
                REG_ZERO_MARK:     cfg_next.zero_mark     = cfg_wr_data[DUR_W-1:0];
                REG_ZERO_SPACE:    cfg_next.zero_space    = cfg_wr_data[DUR_W-1:0];
                REG_FIELD_LENGTHS: cfg_next.field_lengths = cfg_wr_data[LEN_W-1:0];
                REG_FRAME_OPTIONS: cfg_next.frame_options = cfg_wr_data[OPT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/ipfe_sequencer.sv
// Frame sequencer: holds the request and steps through header, field bits and stop item.
// Depends on ipfe_pkg for cfg_t, item_t and the phase codes.
`timescale 1ns / 1ps

module ipfe_sequencer
    import ipfe_pkg::*;
#(
    parameter logic [DUR_W-1:0] STOP_MARK_DUR  = 15'd560,
    parameter logic [DUR_W-1:0] STOP_SPACE_DUR = 15'd0
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [ADDR_W-1:0] req_address,
    input  logic [CMD_W-1:0]  req_command,
    output logic              item_valid,
    input  logic              item_space,
    output item_t             item
);

    logic              busy_reg, busy_next;
    phase_t            phase_reg, phase_next;
    logic [3:0]        bit_idx_reg, bit_idx_next;
    logic [ADDR_W-1:0] held_address_reg, held_address_next;
    logic [CMD_W-1:0]  held_command_reg, held_command_next;

    logic [4:0]        addr_len;
    logic [3:0]        cmd_len;
    logic [4:0]        cur_len;
    logic [PH_NUM-1:0] ph_en;
    phase_t            following;
    logic              has_following;
    logic              phase_end;
    logic              cur_bit;
    logic              load;
    logic              req_take;

    assign addr_len = (cfg.field_lengths[5:0] > 6'(ADDR_MAX_BITS)) ? 5'(ADDR_MAX_BITS)
                                                                    : cfg.field_lengths[4:0];
    assign cmd_len  = (cfg.field_lengths[11:6] > 6'(CMD_MAX_BITS)) ? 4'(CMD_MAX_BITS)
                                                                    : cfg.field_lengths[9:6];

    always_comb begin
        ph_en              = '0;
        ph_en[PH_HEADER]   = 1'b1;
        ph_en[PH_ADDR]     = (addr_len != 5'd0);
        ph_en[PH_ADDR_INV] = (addr_len != 5'd0) && cfg.frame_options[OPT_ADDR_INV];
        ph_en[PH_CMD]      = (cmd_len != 4'd0);
        ph_en[PH_CMD_INV]  = (cmd_len != 4'd0) && cfg.frame_options[OPT_CMD_INV];
        ph_en[PH_STOP]     = cfg.frame_options[OPT_STOP];
    end

    // The nearest enabled phase after the current one; none means this is the final phase.
    always_comb begin
        following     = PH_HEADER;
        has_following = 1'b0;
        for (int p = PH_NUM - 1; p >= 0; p--) begin
            if ((3'(p) > phase_reg) && ph_en[p]) begin
                following     = phase_t'(3'(p));
                has_following = 1'b1;
            end
        end
    end

    always_comb begin
        cur_len = 5'd1;
        cur_bit = 1'b0;
        case (phase_reg)
            PH_ADDR: begin
                cur_len = addr_len;
                cur_bit = held_address_reg[bit_idx_reg];
            end
            PH_ADDR_INV: begin
                cur_len = addr_len;
                cur_bit = ~held_address_reg[bit_idx_reg];
            end
            PH_CMD: begin
                cur_len = {1'b0, cmd_len};
                cur_bit = held_command_reg[bit_idx_reg];
            end
            PH_CMD_INV: begin
                cur_len = {1'b0, cmd_len};
                cur_bit = ~held_command_reg[bit_idx_reg];
            end
            default: begin
                cur_len = 5'd1;
                cur_bit = 1'b0;
            end
        endcase
    end

    assign phase_end = (({1'b0, bit_idx_reg} + 5'd1) == cur_len);

    always_comb begin
        item.last = phase_end && !has_following;
        case (phase_reg)
            PH_HEADER: begin
                item.mark  = cfg.header_mark;
                item.space = cfg.header_space;
            end
            PH_STOP: begin
                item.mark  = STOP_MARK_DUR;
                item.space = STOP_SPACE_DUR;
            end
            default: begin
                item.mark  = cur_bit ? cfg.one_mark  : cfg.zero_mark;
                item.space = cur_bit ? cfg.one_space : cfg.zero_space;
            end
        endcase
    end

    assign item_valid = busy_reg;
    assign load       = busy_reg && item_space;
    // A new request enters as the final item of the current frame leaves.
    assign req_ready  = !busy_reg || (load && item.last);
    assign req_take   = req_valid && req_ready;

    always_comb begin
        busy_next         = busy_reg;
        phase_next        = phase_reg;
        bit_idx_next      = bit_idx_reg;
        held_address_next = held_address_reg;
        held_command_next = held_command_reg;
        if (req_take) begin
            busy_next         = 1'b1;
            phase_next        = PH_HEADER;
            bit_idx_next      = 4'd0;
            held_address_next = req_address;
            held_command_next = req_command;
        end else if (load) begin
            if (item.last) begin
                busy_next = 1'b0;
            end else if (phase_end) begin
                phase_next   = following;
                bit_idx_next = 4'd0;
            end else begin
                bit_idx_next = bit_idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            phase_reg   <= PH_HEADER;
            bit_idx_reg <= 4'd0;
        end else begin
            busy_reg    <= busy_next;
            phase_reg   <= phase_next;
            bit_idx_reg <= bit_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_address_reg <= held_address_next;
        held_command_reg <= held_command_next;
    end

endmodule

>>> rtl/ipfe_out_reg.sv
// Result register of the IR pulse frame encoder; parts the sequencer from the result channel.
// Depends on ipfe_pkg for item_t.
`timescale 1ns / 1ps

module ipfe_out_reg
    import ipfe_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_space,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;
    logic  load;

    assign in_space = !valid_reg || out_ready;
    assign load     = in_valid && in_space;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (load) begin
            valid_next = 1'b1;
            item_next  = in_item;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> rtl/ir_pulse_frame_encoder.sv
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+--------------------------------------
// request   | in        | s_valid / s_ready  | s_address[15:0], s_command[14:0]
// pulse     | out       | m_valid / m_ready  | m_mark_duration, m_space_duration, m_last
// config    | in        | cfg_wr_en          | cfg_wr_index[2:0], cfg_wr_data[14:0]
//
// One request yields 1 to 64 pulse items, one per cycle when m_ready stays high.
// The next request is taken in the cycle the final item of the frame enters the result
// register, so frames follow one another without a gap.
// A stall on m_ready holds the result register and the sequencer; no item is lost.
// Reset clears the configuration registers, the sequencer control state and the result valid flag.
// Depends on ipfe_pkg, ipfe_cfg_regs, ipfe_sequencer and ipfe_out_reg.
`timescale 1ns / 1ps

module ir_pulse_frame_encoder
    import ipfe_pkg::*;
#(
    parameter int unsigned STOP_MARK  = 560,
    parameter int unsigned STOP_SPACE = 0
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [ADDR_W-1:0] s_address,
    input  logic [CMD_W-1:0]  s_command,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DUR_W-1:0]  m_mark_duration,
    output logic [DUR_W-1:0]  m_space_duration,
    output logic              m_last
);

    cfg_t  cfg;
    item_t gen_item;
    item_t out_item;
    logic  gen_valid;
    logic  gen_space;

    ipfe_cfg_regs u_cfg_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    ipfe_sequencer #(
        .STOP_MARK_DUR  (DUR_W'(STOP_MARK)),
        .STOP_SPACE_DUR (DUR_W'(STOP_SPACE))
    ) u_sequencer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .req_valid   (s_valid),
        .req_ready   (s_ready),
        .req_address (s_address),
        .req_command (s_command),
        .item_valid  (gen_valid),
        .item_space  (gen_space),
        .item        (gen_item)
    );

    ipfe_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (gen_valid),
        .in_space  (gen_space),
        .in_item   (gen_item),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (out_item)
    );

    assign m_mark_duration  = out_item.mark;
    assign m_space_duration = out_item.space;
    assign m_last           = out_item.last;

endmodule

>>> rtl/ipfe_checker.sv
// Port-level checks for the IR pulse frame encoder, bound to the top level.
// Depends on ipfe_pkg for the field widths.
`timescale 1ns / 1ps

module ipfe_checker
    import ipfe_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [DUR_W-1:0] m_mark_duration,
    input logic [DUR_W-1:0] m_space_duration,
    input logic             m_last
);

    // Out of reset the block is empty and will take a request.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("block not empty and ready after reset");

    // Once a frame has started its items arrive without a bubble while the sink takes them.
    a_frame_continuous: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("gap inside a frame");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mark_duration)
                                && $stable(m_space_duration) && $stable(m_last))
        else $error("stalled pulse item changed");

endmodule

bind ir_pulse_frame_encoder ipfe_checker u_ipfe_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_mark_duration  (m_mark_duration),
    .m_space_duration (m_space_duration),
    .m_last           (m_last)
);

>>> tb/tb_ir_pulse_frame_encoder.sv
// Self-checking testbench for ir_pulse_frame_encoder: a request driver and a pulse monitor
// check every pulse item against a frame predicted inside the testbench.
// Depends on ipfe_pkg and the encoder RTL.
`timescale 1ns / 1ps

module tb_ir_pulse_frame_encoder;
    import ipfe_pkg::*;

    localparam logic [DUR_W-1:0] STOP_MARK_DUR  = 15'd560;
    localparam logic [DUR_W-1:0] STOP_SPACE_DUR = 15'd0;
    localparam int unsigned      CYCLE_LIMIT    = 400000;
    localparam int               RANDOM_PHASES  = 9;
    localparam int               BATCH_ITEMS    = 26;

    typedef struct {
        logic [ADDR_W-1:0] address;
        logic [CMD_W-1:0]  command;
    } request_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_W-1:0]  cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [ADDR_W-1:0] s_address = '0;
    logic [CMD_W-1:0]  s_command = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [DUR_W-1:0]  m_mark_duration;
    logic [DUR_W-1:0]  m_space_duration;
    logic              m_last;

    request_t    pending_requests[$];
    item_t       expected_pulses[$];
    cfg_t        enc_cfg = '0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          error_count = 0;
    int unsigned cycle_count = 0;

    ir_pulse_frame_encoder #(
        .STOP_MARK  (STOP_MARK_DUR),
        .STOP_SPACE (STOP_SPACE_DUR)
    ) DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_address        (s_address),
        .s_command        (s_command),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_mark_duration  (m_mark_duration),
        .m_space_duration (m_space_duration),
        .m_last           (m_last)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Appends one pulse item per bit, LSB first, and a second pass with every bit
    // inverted when the copy is enabled.
    function automatic void append_field_bits(input logic [15:0] value, input int count,
                                              input bit inverted_copy);
        logic one;
        for (int pass = 0; pass < (inverted_copy ? 2 : 1); pass++) begin
            for (int b = 0; b < count; b++) begin
                one = value[b] ^ (pass == 1);
                if (one) begin
                    expected_pulses.push_back('{mark: enc_cfg.one_mark,
                                                space: enc_cfg.one_space, last: 1'b0});
                end else begin
                    expected_pulses.push_back('{mark: enc_cfg.zero_mark,
                                                space: enc_cfg.zero_space, last: 1'b0});
                end
            end
        end
    endfunction

    function automatic void encode_frame(input logic [ADDR_W-1:0] address,
                                         input logic [CMD_W-1:0] command);
        int addr_bits;
        int cmd_bits;
        addr_bits = int'(enc_cfg.field_lengths[5:0]);
        cmd_bits  = int'(enc_cfg.field_lengths[11:6]);
        if (addr_bits > ADDR_MAX_BITS) addr_bits = ADDR_MAX_BITS;
        if (cmd_bits > CMD_MAX_BITS) cmd_bits = CMD_MAX_BITS;
        expected_pulses.push_back('{mark: enc_cfg.header_mark,
                                    space: enc_cfg.header_space, last: 1'b0});
        append_field_bits(address, addr_bits, enc_cfg.frame_options[OPT_ADDR_INV]);
        append_field_bits({1'b0, command}, cmd_bits, enc_cfg.frame_options[OPT_CMD_INV]);
        if (enc_cfg.frame_options[OPT_STOP]) begin
            expected_pulses.push_back('{mark: STOP_MARK_DUR, space: STOP_SPACE_DUR,
                                        last: 1'b0});
        end
        expected_pulses[$].last = 1'b1;
    endfunction

    always @(posedge aclk) begin : drive_requests
        request_t req;
        logic     next_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                encode_frame(s_address, s_command);
                next_valid = 1'b0;
            end
            if (!next_valid && pending_requests.size() != 0
                && $urandom_range(0, 99) >= send_idle_pct) begin
                req = pending_requests.pop_front();
                s_address  <= req.address;
                s_command  <= req.command;
                next_valid = 1'b1;
            end
            s_valid <= next_valid;
        end
    end

    function automatic void check_field(input string name, input logic [DUR_W-1:0] want,
                                        input logic [DUR_W-1:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : monitor_pulses
        item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pulses.size() == 0) begin
                    error_count++;
                    $display("%0t: extra item, expected none, actual mark %0d space %0d last %0b",
                             $time, m_mark_duration, m_space_duration, m_last);
                end else begin
                    want = expected_pulses.pop_front();
                    check_field("mark_duration", want.mark, m_mark_duration);
                    check_field("space_duration", want.space, m_space_duration);
                    check_field("last", DUR_W'(want.last), DUR_W'(m_last));
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        case (idx)
            REG_HEADER_MARK:   enc_cfg.header_mark   = value;
            REG_HEADER_SPACE:  enc_cfg.header_space  = value;
            REG_ONE_MARK:      enc_cfg.one_mark      = value;
            REG_ONE_SPACE:     enc_cfg.one_space     = value;
            REG_ZERO_MARK:     enc_cfg.zero_mark     = value;
            REG_ZERO_SPACE:    enc_cfg.zero_space    = value;
            REG_FIELD_LENGTHS: enc_cfg.field_lengths = value[LEN_W-1:0];
            REG_FRAME_OPTIONS: enc_cfg.frame_options = value[OPT_W-1:0];
            default: ;
        endcase
    endtask

    // Only called with no request pending and no pulse item outstanding.
    task automatic program_config(input cfg_t c);
        write_reg(REG_HEADER_MARK, c.header_mark);
        write_reg(REG_HEADER_SPACE, c.header_space);
        write_reg(REG_ONE_MARK, c.one_mark);
        write_reg(REG_ONE_SPACE, c.one_space);
        write_reg(REG_ZERO_MARK, c.zero_mark);
        write_reg(REG_ZERO_SPACE, c.zero_space);
        write_reg(REG_FIELD_LENGTHS, CFG_W'(c.field_lengths));
        write_reg(REG_FRAME_OPTIONS, CFG_W'(c.frame_options));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_request(input logic [ADDR_W-1:0] address,
                                input logic [CMD_W-1:0] command);
        pending_requests.push_back('{address: address, command: command});
    endtask

    // Sampled on the falling edge so that every queue update of the rising edge has settled.
    task automatic wait_for_idle();
        do @(negedge aclk);
        while (pending_requests.size() != 0 || s_valid || expected_pulses.size() != 0);
    endtask

    function automatic logic [DUR_W-1:0] pick_duration();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return DUR_W'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        c.header_mark  = pick_duration();
        c.header_space = pick_duration();
        c.one_mark     = pick_duration();
        c.one_space    = pick_duration();
        c.zero_mark    = pick_duration();
        c.zero_space   = pick_duration();
        // Mostly lengths in range; now and then any value, which exercises the clamps.
        if ($urandom_range(0, 3) == 0) begin
            c.field_lengths = LEN_W'($urandom);
        end else begin
            c.field_lengths = {6'($urandom_range(0, CMD_MAX_BITS)),
                               6'($urandom_range(0, ADDR_MAX_BITS))};
        end
        c.frame_options = OPT_W'($urandom_range(0, 7));
        return c;
    endfunction

    initial begin
        cfg_t c;
        send_idle_pct  = 19;
        recv_stall_pct = 62;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Full-length frame of 64 items with every option and extreme durations.
        c = '{header_mark: 15'h7FFF, header_space: 15'h0000, one_mark: 15'h7FFF,
              one_space: 15'h0001, zero_mark: 15'h0000, zero_space: 15'h7FFF,
              field_lengths: {6'd15, 6'd16}, frame_options: 3'b111};
        program_config(c);
        send_request(16'h0000, 15'h0000);
        send_request(16'hFFFF, 15'h7FFF);
        send_request(16'hAAAA, 15'h2AAA);
        send_request(16'h5555, 15'h5555);
        send_request(16'h0001, 15'h4000);
        wait_for_idle();

        // Both lengths far above their limits, so both are clamped.
        c = '{header_mark: 15'd9000, header_space: 15'd4500, one_mark: 15'd560,
              one_space: 15'd1690, zero_mark: 15'd560, zero_space: 15'd560,
              field_lengths: 12'hFFF, frame_options: 3'b000};
        program_config(c);
        send_request(16'h8001, 15'h4001);
        send_request(16'h1234, 15'h0F0F);
        send_request(16'hFFFF, 15'h0000);
        wait_for_idle();

        // Zero lengths: header plus stop item only.
        c = '{header_mark: 15'h0000, header_space: 15'h0000, one_mark: 15'h7FFF,
              one_space: 15'h7FFF, zero_mark: 15'h7FFF, zero_space: 15'h7FFF,
              field_lengths: 12'h000, frame_options: 3'b100};
        program_config(c);
        send_request(16'hFFFF, 15'h7FFF);
        send_request(16'h0000, 15'h0000);
        wait_for_idle();

        // Zero lengths with both inverted copies enabled: the header alone ends the frame.
        c.frame_options = 3'b011;
        program_config(c);
        send_request(16'h5A5A, 15'h25A5);
        send_request(16'hA5A5, 15'h5A5A);
        wait_for_idle();

        // Lengths one above each limit, with address copy and stop.
        c = '{header_mark: 15'd1, header_space: 15'd2, one_mark: 15'd3, one_space: 15'd4,
              zero_mark: 15'd5, zero_space: 15'd6, field_lengths: {6'd16, 6'd17},
              frame_options: 3'b101};
        program_config(c);
        send_request(16'hC003, 15'h6001);
        send_request(16'h3FFC, 15'h1FFE);
        wait_for_idle();

        // A single address bit; the command copy is enabled on an empty command field.
        c.field_lengths = {6'd0, 6'd1};
        c.frame_options = 3'b010;
        program_config(c);
        send_request(16'h0001, 15'h7FFF);
        send_request(16'hFFFE, 15'h0000);
        wait_for_idle();

        // No address bits but a full command with its inverted copy.
        c.field_lengths = {6'd15, 6'd0};
        c.frame_options = 3'b011;
        program_config(c);
        send_request(16'hFFFF, 15'h3C3C);
        wait_for_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph < RANDOM_PHASES / 3) begin
                send_idle_pct  = 19;
                recv_stall_pct = 62;
            end else if (ph < 2 * RANDOM_PHASES / 3) begin
                send_idle_pct  = 62;
                recv_stall_pct = 19;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            program_config(random_config());
            // Two batches per setting; the sender holds back between them until every
            // pulse item of the first batch has been taken.
            for (int batch = 0; batch < 2; batch++) begin
                for (int n = 0; n < BATCH_ITEMS; n++) begin
                    send_request(ADDR_W'($urandom), CMD_W'($urandom));
                end
                wait_for_idle();
            end
        end

        repeat (20) @(posedge aclk);
        if (error_count == 0 && expected_pulses.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/ipfe_pkg.sv
rtl/ipfe_cfg_regs.sv
rtl/ipfe_sequencer.sv
rtl/ipfe_out_reg.sv
rtl/ir_pulse_frame_encoder.sv
rtl/ipfe_checker.sv
tb/tb_ir_pulse_frame_encoder.sv
